/* hdl/jsu_pkg.sv */
// shared types and constants for the json string unescape unit
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned GROUP_BYTES = 4;

  localparam logic [1:0] ST_PROG = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_BODY = 4'd1,
    PH_ESC  = 4'd2,
    PH_HI0  = 4'd3,
    PH_HI1  = 4'd4,
    PH_HI2  = 4'd5,
    PH_HI3  = 4'd6,
    PH_BSL  = 4'd7,
    PH_U    = 4'd8,
    PH_LO0  = 4'd9,
    PH_LO1  = 4'd10,
    PH_LO2  = 4'd11,
    PH_LO3  = 4'd12,
    PH_DONE = 4'd13,
    PH_ERR  = 4'd14
  } phase_t;

  // results caused by one input word: nbytes decoded bytes, or one status word
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [2:0]                  nbytes;
    logic [1:0]                  status;
  } group_t;

endpackage

/* hdl/jsu_front.sv */
// parser front end: classifies each byte and builds its group of results
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       start_req,
  output group_t     grp
);

  phase_t      phase, phase_next;
  logic [15:0] hex_acc, hex_acc_next;
  logic [9:0]  hi_bits, hi_bits_next;
  logic [1:0]  pend, pend_next;
  logic [20:0] part, part_next;
  logic [1:0]  cls, cls_next;

  // state as seen by this word, after an optional restart
  phase_t      ph;
  logic [15:0] acc_e;
  logic [9:0]  hi_e;
  logic [1:0]  pend_e;
  logic [20:0] part_e;
  logic [1:0]  cls_e;

  logic [4:0]  hex_d;
  logic [15:0] acc_new;
  logic [7:0]  esc_byte;
  logic        esc_ok;
  logic [7:0]  sb;
  logic        t_ok;
  logic [1:0]  t_pend;
  logic [20:0] t_part;
  logic [1:0]  t_cls;
  logic [20:0] t_cp;
  logic [20:0] t_min;
  logic [20:0] cp;
  logic [3:0][7:0] enc;
  logic [2:0]  enc_n;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b0, b[3:0] + 4'd9};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_WAIT;
      hex_acc <= '0;
      hi_bits <= '0;
      pend    <= '0;
      part    <= '0;
      cls     <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      hex_acc <= hex_acc_next;
      hi_bits <= hi_bits_next;
      pend    <= pend_next;
      part    <= part_next;
      cls     <= cls_next;
    end
  end

  always_comb begin
    ph     = start_req ? PH_WAIT : phase;
    acc_e  = start_req ? 16'd0 : hex_acc;
    hi_e   = start_req ? 10'd0 : hi_bits;
    pend_e = start_req ? 2'd0 : pend;
    part_e = start_req ? 21'd0 : part;
    cls_e  = start_req ? 2'd0 : cls;
  end

  assign hex_d   = hex_val(in_byte);
  assign acc_new = {acc_e[11:0], hex_d[3:0]};

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
      8'h62:               esc_byte = 8'h08;
      8'h66:               esc_byte = 8'h0C;
      8'h6E:               esc_byte = 8'h0A;
      8'h72:               esc_byte = 8'h0D;
      8'h74:               esc_byte = 8'h09;
      default:             esc_ok   = 1'b0;
    endcase
  end

  // utf-8 check of one emitted byte
  assign sb = (ph == PH_ESC) ? esc_byte : in_byte;
  assign t_cp = {part_e[14:0], sb[5:0]};
  always_comb begin
    t_ok   = 1'b1;
    t_pend = pend_e;
    t_part = part_e;
    t_cls  = cls_e;
    unique case (cls_e)
      2'd1:    t_min = 21'h80;
      2'd2:    t_min = 21'h800;
      default: t_min = 21'h10000;
    endcase
    if (pend_e == 2'd0) begin
      priority if (sb < 8'h80) begin
        t_ok = 1'b1;
      end else if ((sb & 8'hE0) == 8'hC0) begin
        t_pend = 2'd1; t_part = {16'd0, sb[4:0]}; t_cls = 2'd1;
      end else if ((sb & 8'hF0) == 8'hE0) begin
        t_pend = 2'd2; t_part = {17'd0, sb[3:0]}; t_cls = 2'd2;
      end else if ((sb & 8'hF8) == 8'hF0) begin
        t_pend = 2'd3; t_part = {18'd0, sb[2:0]}; t_cls = 2'd3;
      end else begin
        t_ok = 1'b0;
      end
    end else if ((sb & 8'hC0) != 8'h80) begin
      t_ok = 1'b0;
    end else begin
      t_part = t_cp;
      t_pend = pend_e - 2'd1;
      if (pend_e == 2'd1 && (t_cp < t_min || t_cp > 21'h10FFFF ||
                             (t_cp >= 21'hD800 && t_cp <= 21'hDFFF)))
        t_ok = 1'b0;
    end
  end

  // code point of a finished \u escape and its utf-8 form
  assign cp = (ph == PH_LO3) ? 21'h10000 + {1'b0, hi_e, acc_new[9:0]}
                             : {5'd0, acc_new};
  always_comb begin
    enc = '0;
    priority if (cp <= 21'h7F) begin
      enc[0] = cp[7:0];
      enc_n  = 3'd1;
    end else if (cp <= 21'h7FF) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      enc_n  = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      enc_n  = 3'd3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      enc_n  = 3'd4;
    end
  end

  always_comb begin
    phase_next   = ph;
    hex_acc_next = acc_e;
    hi_bits_next = hi_e;
    pend_next    = pend_e;
    part_next    = part_e;
    cls_next     = cls_e;
    grp          = '0;
    grp.status   = ST_PROG;
    priority if (ph == PH_DONE) begin
      grp.status = ST_DONE;
    end else if (ph == PH_ERR) begin
      grp.status = ST_ERR;
    end else if (end_of_text) begin
      phase_next = PH_ERR;
      grp.status = ST_ERR;
    end else begin
      unique case (ph)
        PH_WAIT: begin
          if (in_byte == 8'h22) phase_next = PH_BODY;
          else if (!(in_byte == 8'h20 || (in_byte >= 8'h09 && in_byte <= 8'h0D)))
            phase_next = PH_ERR;
        end
        PH_BODY: begin
          priority if (in_byte == 8'h22) begin
            if (pend_e != 2'd0) begin
              phase_next = PH_ERR;
            end else begin
              phase_next = PH_DONE;
              grp.status = ST_DONE;
            end
          end else if (in_byte < 8'h20) begin
            phase_next = PH_ERR;
          end else if (in_byte == 8'h5C) begin
            phase_next = PH_ESC;
          end else if (!t_ok) begin
            phase_next = PH_ERR;
          end else begin
            grp.bytes[0] = sb;
            grp.nbytes   = 3'd1;
            pend_next    = t_pend;
            part_next    = t_part;
            cls_next     = t_cls;
          end
        end
        PH_ESC: begin
          priority if (in_byte == 8'h75) begin
            phase_next   = PH_HI0;
            hex_acc_next = '0;
          end else if (!esc_ok || !t_ok) begin
            phase_next = PH_ERR;
          end else begin
            phase_next   = PH_BODY;
            grp.bytes[0] = sb;
            grp.nbytes   = 3'd1;
            pend_next    = t_pend;
            part_next    = t_part;
            cls_next     = t_cls;
          end
        end
        PH_BSL: phase_next = (in_byte == 8'h5C) ? PH_U : PH_ERR;
        PH_U: begin
          if (in_byte == 8'h75) begin
            phase_next   = PH_LO0;
            hex_acc_next = '0;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_HI0, PH_HI1, PH_HI2, PH_LO0, PH_LO1, PH_LO2: begin
          hex_acc_next = acc_new;
          phase_next   = hex_d[4] ? PH_ERR : phase_t'(ph + 4'd1);
        end
        PH_HI3: begin
          hex_acc_next = acc_new;
          priority if (hex_d[4]) begin
            phase_next = PH_ERR;
          end else if (acc_new < 16'hD800 || acc_new > 16'hDFFF) begin
            // an open raw sequence cannot take a fresh lead byte
            if (pend_e != 2'd0) begin
              phase_next = PH_ERR;
            end else begin
              phase_next = PH_BODY;
              grp.bytes  = enc;
              grp.nbytes = enc_n;
            end
          end else if (acc_new > 16'hDBFF) begin
            phase_next = PH_ERR;
          end else begin
            hi_bits_next = acc_new[9:0];
            phase_next   = PH_BSL;
          end
        end
        PH_LO3: begin
          hex_acc_next = acc_new;
          if (hex_d[4] || acc_new < 16'hDC00 || acc_new > 16'hDFFF || pend_e != 2'd0) begin
            phase_next = PH_ERR;
          end else begin
            phase_next = PH_BODY;
            grp.bytes  = enc;
            grp.nbytes = enc_n;
          end
        end
        default: phase_next = PH_ERR;
      endcase
      if (phase_next == PH_ERR) begin
        grp.status = ST_ERR;
        grp.nbytes = '0;
        grp.bytes  = '0;
      end
    end
  end

endmodule

/* hdl/jsu_queue.sv */
// short queue of result groups between parser and output stage
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  group_t wr_data,
  input  logic   rd_en,
  output group_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  group_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

/* hdl/jsu_back.sv */
// output stage: hands out the words of the head group one at a time
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  group_t     head,
  input  logic       head_empty,
  input  logic       pop,
  output logic       head_pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  logic [1:0] idx;
  logic       has_bytes;

  assign has_bytes  = (head.nbytes != 3'd0);
  assign byte_valid = has_bytes;
  assign out_byte   = has_bytes ? head.bytes[idx] : 8'd0;
  assign status     = has_bytes ? ST_PROG : head.status;
  assign last       = !has_bytes || (({1'b0, idx} + 3'd1) == head.nbytes);
  assign head_pop   = pop && !head_empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !head_empty) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

/* hdl/json_string_unescape_utf8_unit.sv */
// latency: a word pushed at one edge can be popped from the next cycle on
// throughput: one input word per cycle while not full; each result word takes
// one pop, so a \u escape of up to four bytes holds the output that many pops
// the group queue between parser and output stage sets how far the sides drift
// reset: synchronous, parser back to waiting for the opening quote, queue empty
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       start_req,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  group_t grp, head;
  logic   accept, head_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .start_req   (start_req),
    .grp         (grp)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (grp),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .pop        (pop),
    .head_pop   (head_pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .last       (last)
  );

endmodule

/* hdl/jsu_checker.sv */
// port-level checks for the json string unescape unit
module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] status,
  input logic       last
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

  a_byte_in_progress: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_valid) |-> (status == ST_PROG))
    else $error("decoded byte with final status");

  a_status_word_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (last && out_byte == 8'd0))
    else $error("status word not alone or carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= ST_ERR))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(status)))
    else $error("waiting word changed");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .status     (status),
  .last       (last)
);
